// ===== rtl/core/tlvd_pkg.sv =====
// ----------------------------------------------------------------------------
// tlvd_pkg
// Types and constants of the TLV record deframer with LEB128 lengths.
// ----------------------------------------------------------------------------
package tlvd_pkg;

    // width of a decoded record length
    localparam int LEN_WIDTH   = 32;
    // most LEB128 bytes that a length may take
    localparam int LEN_GROUPS  = (LEN_WIDTH + 6) / 7;
    localparam int LEN_SHIFT_W = $clog2(LEN_GROUPS + 1);
    localparam int LEN_POS_W   = $clog2(7 * LEN_GROUPS);

    localparam int HDR_LEN  = 6;
    localparam int HDR_IDX_W = $clog2(HDR_LEN);

    localparam logic [7:0] MAGIC [4] = '{8'h58, 8'h50, 8'h52, 8'h46};
    localparam logic [7:0] HDR_VERSION = 8'h01;
    localparam logic [7:0] TYPE_PASS_MIN = 8'h01;
    localparam logic [7:0] TYPE_PASS_MAX = 8'h04;

    typedef enum logic [3:0] {
        K_HDR_PEND  = 4'd0,
        K_HDR_DONE  = 4'd1,
        K_TYPE      = 4'd2,
        K_LEN_BYTE  = 4'd3,
        K_REC_START = 4'd4,
        K_PAYLOAD   = 4'd5,
        K_SKIPPED   = 4'd6,
        K_RAW       = 4'd7,
        K_ERROR     = 4'd8,
        K_IGNORED   = 4'd9
    } t_kind;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_SHORT     = 3'd1,
        ERR_MAGIC     = 3'd2,
        ERR_VERSION   = 3'd3,
        ERR_OVERRUN   = 3'd4,
        ERR_LEN_OVFL  = 3'd5
    } t_err;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       final_byte;
    } t_in_item;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  record_type;
        logic [31:0] record_length;
        logic [7:0]  data_byte;
        logic        last_of_record;
        logic        compressed;
        logic        end_of_data;
        t_err        error_code;
    } t_out_item;

endpackage

// ===== rtl/core/tlv_leb128_record_deframer_unit.sv =====
// ----------------------------------------------------------------------------
// tlv_leb128_record_deframer_unit
// Header check and TLV record split of a byte stream with LEB128 lengths.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_in_valid / o_in_stall carry one file byte per item with
//   a mark on the last byte of the file. Output channel: o_out_valid /
//   i_out_stall carry one result item for every input item, in order.
//   An item moves at a clock edge with valid high and stall low.
//   The result of a byte sits in the output register in the cycle after it
//   is taken. Throughput is one byte per cycle while the receiver does not
//   stall; the per-byte state update and the output register set that figure.
//   While the receiver stalls and a result is held, o_in_stall is high; as
//   soon as the held result is taken, a new byte is accepted in the same
//   cycle.
//   Reset (synchronous, active low) empties the output register and puts the
//   parser back at the start of a header. Each byte with the end mark also
//   returns the parser to that state, ready for the next file.
//   After an error, bytes up to the end mark are reported as ignored.
// ----------------------------------------------------------------------------
module tlv_leb128_record_deframer_unit
    import tlvd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    typedef enum logic [8:0] {
        PH_HDR       = 9'b000000001,
        PH_HDR_MAGIC = 9'b000000010,
        PH_HDR_VER   = 9'b000000100,
        PH_TYPE      = 9'b000001000,
        PH_LEN       = 9'b000010000,
        PH_PAY       = 9'b000100000,
        PH_SKIP      = 9'b001000000,
        PH_RAW       = 9'b010000000,
        PH_IGN       = 9'b100000000
    } t_phase;

    t_phase                 r_phase,   n_phase;
    logic [HDR_IDX_W-1:0]   r_hdr_idx, n_hdr_idx;
    logic [7:0]             r_type,    n_type;
    logic [LEN_WIDTH-1:0]   r_acc,     n_acc;
    logic [LEN_SHIFT_W-1:0] r_shift,   n_shift;
    logic [LEN_WIDTH-1:0]   r_rem,     n_rem;
    logic                   r_comp,    n_comp;

    logic      r_out_valid;
    t_out_item r_out, n_out;

    logic                 accept;
    logic [7:0]           b;
    logic                 fin;
    logic [LEN_POS_W-1:0] pos;
    logic [LEN_WIDTH+6:0] grp;
    logic                 over;
    logic                 cont;
    logic [LEN_WIDTH-1:0] len_new;
    logic [LEN_WIDTH-1:0] rem_dec;

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign b   = i_in_item.byte_value;
    assign fin = i_in_item.final_byte;

    // LEB128 group placement and overflow check
    assign pos     = LEN_POS_W'(r_shift) * LEN_POS_W'(7);
    assign grp     = (LEN_WIDTH + 7)'(b[6:0]) << pos;
    assign cont    = b[7];
    assign len_new = r_acc | grp[LEN_WIDTH-1:0];
    assign over    = (r_shift >= LEN_SHIFT_W'(LEN_GROUPS))
                  || (|grp[LEN_WIDTH+6:LEN_WIDTH])
                  || (cont && (r_shift == LEN_SHIFT_W'(LEN_GROUPS - 1)));
    assign rem_dec = r_rem - LEN_WIDTH'(1);

    always_comb begin
        t_err   err;
        logic   failed;
        t_phase hp;

        n_phase   = r_phase;
        n_hdr_idx = r_hdr_idx;
        n_type    = r_type;
        n_acc     = r_acc;
        n_shift   = r_shift;
        n_rem     = r_rem;
        n_comp    = r_comp;
        err       = ERR_NONE;
        failed    = 1'b0;
        hp        = r_phase;

        n_out                = '0;
        n_out.kind           = K_IGNORED;
        n_out.error_code     = ERR_NONE;
        n_out.end_of_data    = fin;

        unique case (r_phase)
            PH_HDR, PH_HDR_MAGIC, PH_HDR_VER: begin
                if (r_hdr_idx < HDR_IDX_W'(4)) begin
                    if (b != MAGIC[r_hdr_idx[1:0]] && r_phase == PH_HDR) begin
                        hp = PH_HDR_MAGIC;
                    end
                end else if (r_hdr_idx == HDR_IDX_W'(4)) begin
                    if (b != HDR_VERSION && r_phase == PH_HDR) begin
                        hp = PH_HDR_VER;
                    end
                end
                n_phase = hp;
                if (r_hdr_idx < HDR_IDX_W'(HDR_LEN - 1)) begin
                    if (fin) begin
                        failed = 1'b1;
                        err    = ERR_SHORT;
                    end else begin
                        n_out.kind = K_HDR_PEND;
                        n_hdr_idx  = r_hdr_idx + HDR_IDX_W'(1);
                    end
                end else if (hp == PH_HDR_MAGIC) begin
                    failed = 1'b1;
                    err    = ERR_MAGIC;
                end else if (hp == PH_HDR_VER) begin
                    failed = 1'b1;
                    err    = ERR_VERSION;
                end else begin
                    n_comp     = b[0];
                    n_out.kind = K_HDR_DONE;
                    n_phase    = b[0] ? PH_RAW : PH_TYPE;
                end
            end
            PH_TYPE: begin
                n_type = b;
                if (fin) begin
                    failed = 1'b1;
                    err    = ERR_OVERRUN;
                end else begin
                    n_out.kind = K_TYPE;
                    n_acc      = '0;
                    n_shift    = '0;
                    n_phase    = PH_LEN;
                end
            end
            PH_LEN: begin
                n_acc = len_new;
                if (over) begin
                    failed = 1'b1;
                    err    = ERR_LEN_OVFL;
                end else if (cont) begin
                    n_shift = r_shift + LEN_SHIFT_W'(1);
                    if (fin) begin
                        failed = 1'b1;
                        err    = ERR_OVERRUN;
                    end else begin
                        n_out.kind = K_LEN_BYTE;
                    end
                end else if (fin && len_new != '0) begin
                    failed = 1'b1;
                    err    = ERR_OVERRUN;
                end else begin
                    n_out.kind           = K_REC_START;
                    n_out.record_length  = 32'(len_new);
                    n_out.last_of_record = (len_new == '0);
                    n_rem                = len_new;
                    if (len_new == '0) begin
                        n_phase = PH_TYPE;
                    end else if (r_type >= TYPE_PASS_MIN && r_type <= TYPE_PASS_MAX) begin
                        n_phase = PH_PAY;
                    end else begin
                        n_phase = PH_SKIP;
                    end
                end
            end
            PH_PAY, PH_SKIP: begin
                n_rem = rem_dec;
                if (fin && rem_dec != '0) begin
                    failed = 1'b1;
                    err    = ERR_OVERRUN;
                end else begin
                    n_out.kind           = (r_phase == PH_PAY) ? K_PAYLOAD : K_SKIPPED;
                    n_out.data_byte      = (r_phase == PH_PAY) ? b : 8'h00;
                    n_out.last_of_record = (rem_dec == '0);
                    if (rem_dec == '0) begin
                        n_phase = PH_TYPE;
                    end
                end
            end
            PH_RAW: begin
                n_out.kind      = K_RAW;
                n_out.data_byte = b;
            end
            default: begin
                n_out.kind = K_IGNORED;
                n_phase    = PH_IGN;
            end
        endcase

        if (failed) begin
            n_out.kind           = K_ERROR;
            n_out.error_code     = err;
            n_out.record_length  = '0;
            n_out.data_byte      = '0;
            n_out.last_of_record = 1'b0;
            n_phase              = PH_IGN;
        end

        // result carries the type and flag as known after this byte
        n_out.record_type = n_type;
        n_out.compressed  = n_comp;

        // end mark: back to the start of a header
        if (fin) begin
            n_phase   = PH_HDR;
            n_hdr_idx = '0;
            n_type    = '0;
            n_acc     = '0;
            n_shift   = '0;
            n_rem     = '0;
            n_comp    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HDR;
            r_hdr_idx   <= '0;
            r_type      <= '0;
            r_acc       <= '0;
            r_shift     <= '0;
            r_rem       <= '0;
            r_comp      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_phase     <= n_phase;
                r_hdr_idx   <= n_hdr_idx;
                r_type      <= n_type;
                r_acc       <= n_acc;
                r_shift     <= n_shift;
                r_rem       <= n_rem;
                r_comp      <= n_comp;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    // an error code only travels with an error result
    a_err_only_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.error_code != ERR_NONE |-> o_out_item.kind == K_ERROR)
        else $error("error code on a non-error result");

    // an end mark puts the parser back at the header start
    a_fin_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_in_item.final_byte |=> r_phase == PH_HDR && r_hdr_idx == '0
            && o_out_item.end_of_data)
        else $error("parser not reset after end mark");

    // a record body never waits with nothing left to take
    a_rem_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAY || r_phase == PH_SKIP) |-> r_rem != '0)
        else $error("payload phase with no bytes remaining");

    // stall toward the sender only while a result is held
    a_stall_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_out_valid && i_out_stall)
        else $error("input stalled without a held result");

endmodule
